FILE: rtl/qat_pkg.sv
// Shared types, constants and per-byte tokenizer functions for the quoted argument tokenizer.
package qat_pkg;

  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] ADDR_MAX_TOKENS = 2'd0;
  localparam logic [7:0] MAX_TOKENS_RESET = 8'd64;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW = $clog2(RQ_DEPTH);
  localparam int RQ_CW = RQ_AW + 1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_R = 8'h72;
  localparam logic [7:0] CH_LOW_N = 8'h6E;
  localparam logic [7:0] CH_LOW_T = 8'h74;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_STR  = 2'd2,
    MODE_ESC  = 2'd3
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic       tend;
    logic [7:0] cnt;
    logic       ovf;
    logic       line_done;
    logic       last;
  } result_t;

  // Scanner state plus the results collected for the current item.
  typedef struct packed {
    scan_mode_t     mode;
    logic [7:0]     kept;
    logic           dropped;
    logic           cdrop;
    logic [1:0]     n;
    result_t [1:0]  ev;
  } work_t;

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic work_t tk_append(work_t w, logic [7:0] c, logic v);
    work_t r;
    r = w;
    if (w.n != 2'd2) begin
      r.ev[w.n[0]].ch = v ? c : 8'h00;
      r.ev[w.n[0]].valid = v;
      r.ev[w.n[0]].tend = 1'b0;
      r.ev[w.n[0]].cnt = w.kept;
      r.ev[w.n[0]].ovf = w.dropped;
      r.ev[w.n[0]].line_done = 1'b0;
      r.ev[w.n[0]].last = 1'b0;
      r.n = w.n + 2'd1;
    end
    return r;
  endfunction

  function automatic work_t tk_start(work_t w, logic [7:0] max_tokens);
    work_t r;
    r = w;
    if (w.kept >= max_tokens) begin
      r.cdrop = 1'b1;
      r.dropped = 1'b1;
    end else begin
      r.cdrop = 1'b0;
    end
    return r;
  endfunction

  function automatic work_t tk_put(work_t w, logic [7:0] c);
    work_t r;
    r = w;
    if (!w.cdrop) begin
      r = tk_append(w, c, 1'b1);
    end
    return r;
  endfunction

  // With one or two results collected, n[1] selects the most recent one.
  function automatic work_t tk_end(work_t w);
    work_t r;
    r = w;
    if (!w.cdrop) begin
      r.kept = w.kept + 8'd1;
      if ((r.n == 2'd0) || r.ev[r.n[1]].tend) begin
        r = tk_append(r, 8'h00, 1'b0);
      end
      if (r.n != 2'd0) begin
        r.ev[r.n[1]].tend = 1'b1;
        r.ev[r.n[1]].cnt = r.kept;
      end
    end
    r.cdrop = 1'b0;
    r.mode = MODE_IDLE;
    return r;
  endfunction

  function automatic work_t tk_in_string(work_t w, logic [7:0] c);
    work_t r;
    r = w;
    if (c == CH_QUOTE) begin
      r = tk_end(w);
    end else if (c == CH_BSLASH) begin
      r.mode = MODE_ESC;
    end else begin
      r = tk_put(w, c);
    end
    return r;
  endfunction

  function automatic work_t tk_escape(work_t w, logic [7:0] c);
    work_t r;
    r = w;
    r.mode = MODE_STR;
    case (c)
      CH_LOW_R: r = tk_put(r, CH_CR);
      CH_LOW_N: r = tk_put(r, CH_LF);
      CH_LOW_T: r = tk_put(r, CH_TAB);
      CH_QUOTE: r = tk_put(r, CH_QUOTE);
      default: begin
        r = tk_put(r, CH_BSLASH);
        r = tk_in_string(r, c);
      end
    endcase
    return r;
  endfunction

  // One byte through the scanner; the caller clears the result count first.
  function automatic work_t tk_step(work_t w, logic [7:0] c, logic eol,
                                    logic [7:0] max_tokens);
    work_t r;
    r = w;
    case (w.mode)
      MODE_IDLE: begin
        if (!is_ws(c)) begin
          r = tk_start(r, max_tokens);
          if (c == CH_QUOTE) begin
            r.mode = MODE_STR;
          end else begin
            r.mode = MODE_WORD;
            r = tk_put(r, c);
          end
        end
      end
      MODE_WORD: begin
        if (is_ws(c)) begin
          r = tk_end(r);
        end else begin
          r = tk_put(r, c);
        end
      end
      MODE_STR: r = tk_in_string(r, c);
      default: r = tk_escape(r, c);
    endcase
    if (eol) begin
      if (r.mode != MODE_IDLE) begin
        if (r.mode == MODE_ESC) begin
          r = tk_put(r, CH_BSLASH);
        end
        r = tk_end(r);
      end
      if (r.n == 2'd0) begin
        r = tk_append(r, 8'h00, 1'b0);
      end
    end
    if (r.n != 2'd0) begin
      r.ev[r.n[1]].last = 1'b1;
      r.ev[r.n[1]].line_done = eol;
    end
    if (eol) begin
      r.mode = MODE_IDLE;
      r.kept = 8'd0;
      r.dropped = 1'b0;
      r.cdrop = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: rtl/quoted_argument_tokenizer_unit.sv
// Top level of the quoted argument tokenizer: scanner state, config register, result queue.
// Each accepted byte's results are written into the result queue and offered from its head.
// Input: one byte per cycle while in_stall is low; a byte that yields two results takes two
// output transfers, and the four-entry result queue stalls input when fewer than two are free.
// Reset (synchronous, rst_n low): scanner returns to between tokens, counts and flags
// clear, the queue empties and max_tokens returns to 64.
module quoted_argument_tokenizer_unit
  import qat_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_byte,
  input  logic                  in_end_of_line,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_char,
  output logic                  out_char_valid,
  output logic                  out_token_end,
  output logic [7:0]            out_token_count,
  output logic                  out_overflow,
  output logic                  out_line_done,
  output logic                  out_last_in_run,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  scan_mode_t mode_r, mode_nxt;
  logic [7:0] kept_r, kept_nxt;
  logic       dropped_r, dropped_nxt;
  logic       cdrop_r, cdrop_nxt;
  logic [7:0] max_tokens_r;

  work_t            w;
  logic             in_accept;
  logic [1:0]       push_n;
  result_t          head;
  logic [RQ_CW-1:0] count;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MAX_TOKENS) ? {24'd0, max_tokens_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tokens_r <= MAX_TOKENS_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_MAX_TOKENS)) begin
      max_tokens_r <= pwdata[7:0];
    end
  end

  // Hold off input unless the queue has room for the two results a byte can make.
  assign in_stall = (count > RQ_CW'(RQ_DEPTH - 2));
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    w = '0;
    w.mode = mode_r;
    w.kept = kept_r;
    w.dropped = dropped_r;
    w.cdrop = cdrop_r;
    w = tk_step(w, in_byte, in_end_of_line, max_tokens_r);

    mode_nxt = mode_r;
    kept_nxt = kept_r;
    dropped_nxt = dropped_r;
    cdrop_nxt = cdrop_r;
    push_n = 2'd0;
    if (in_accept) begin
      mode_nxt = w.mode;
      kept_nxt = w.kept;
      dropped_nxt = w.dropped;
      cdrop_nxt = w.cdrop;
      push_n = w.n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      kept_r <= 8'd0;
      dropped_r <= 1'b0;
      cdrop_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      kept_r <= kept_nxt;
      dropped_r <= dropped_nxt;
      cdrop_r <= cdrop_nxt;
    end
  end

  qat_result_fifo u_result_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push_data (w.ev),
    .pop       (out_valid && !out_stall),
    .head      (head),
    .count     (count)
  );

  assign out_valid = (count != '0);
  assign out_char = head.ch;
  assign out_char_valid = head.valid;
  assign out_token_end = head.tend;
  assign out_token_count = head.cnt;
  assign out_overflow = head.ovf;
  assign out_line_done = head.line_done;
  assign out_last_in_run = head.last;

endmodule

FILE: rtl/qat_result_fifo.sv
// Small result queue that takes up to two results per cycle and hands out one.
module qat_result_fifo
  import qat_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         push_n,
  input  result_t [1:0]      push_data,
  input  logic               pop,
  output result_t            head,
  output logic [RQ_CW-1:0]   count
);

  result_t mem_r [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RQ_CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RQ_AW'(push_n);
    rd_ptr_nxt = rd_ptr_r + RQ_AW'(pop);
    count_nxt = count_r + RQ_CW'(push_n) - RQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push_data[0];
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_r + RQ_AW'(1)] <= push_data[1];
    end
  end

  assign head = mem_r[rd_ptr_r];
  assign count = count_r;

endmodule

FILE: verif/tb_quoted_argument_tokenizer_unit.sv
// Self-checking testbench for the quoted argument tokenizer: directed table, random lines.
`timescale 1ns / 100ps

module tb_quoted_argument_tokenizer_unit;
  import qat_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_LONG = 40;
  localparam int PHASE_ITEMS = 115;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic       tend;
    logic [7:0] cnt;
    logic       ovf;
    logic       ldone;
    logic       last;
  } tok_result_t;

  typedef struct {
    bit          is_cfg;
    logic [7:0]  b;
    logic        eol;
    bit          typed;
    tok_result_t ex;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [7:0] in_byte;
  logic in_end_of_line;
  logic out_valid;
  logic out_stall;
  logic [7:0] out_char;
  logic out_char_valid;
  logic out_token_end;
  logic [7:0] out_token_count;
  logic out_overflow;
  logic out_line_done;
  logic out_last_in_run;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // Typed expectation that travels with the item on the input channel.
  bit row_typed;
  tok_result_t row_expect;

  tok_result_t tok_out_q[$];
  dir_row_t dir_tab[$];
  logic [7:0] line_q[$];
  int fail_count = 0;
  int cyc_count = 0;
  bit quiet = 1'b0;
  int hold_cycles = 0;

  // Predictor state and the results of the current byte.
  scan_mode_t pm_mode;
  logic [7:0] pm_kept;
  logic [7:0] pm_max;
  logic pm_dropped;
  logic pm_cur_drop;
  tok_result_t stp_ev[2];
  int stp_n;

  quoted_argument_tokenizer_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .in_end_of_line(in_end_of_line),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char(out_char),
    .out_char_valid(out_char_valid),
    .out_token_end(out_token_end),
    .out_token_count(out_token_count),
    .out_overflow(out_overflow),
    .out_line_done(out_line_done),
    .out_last_in_run(out_last_in_run),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cyc_count <= cyc_count + 1;
    if (cyc_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic bit is_blank(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic void emit(logic [7:0] c, logic v);
    if (stp_n < 2) begin
      stp_ev[stp_n] = '{ch: v ? c : 8'h00, valid: v, tend: 1'b0, cnt: pm_kept,
                        ovf: pm_dropped, ldone: 1'b0, last: 1'b0};
      stp_n++;
    end
  endfunction

  function automatic void put_char_out(logic [7:0] c);
    if (!pm_cur_drop) begin
      emit(c, 1'b1);
    end
  endfunction

  // The end mark rides on the last result of this byte unless that one already ends a token.
  function automatic void close_token();
    if (!pm_cur_drop) begin
      pm_kept = pm_kept + 8'd1;
      if ((stp_n == 0) || stp_ev[stp_n-1].tend) begin
        emit(8'h00, 1'b0);
      end
      if (stp_n > 0) begin
        stp_ev[stp_n-1].tend = 1'b1;
        stp_ev[stp_n-1].cnt = pm_kept;
      end
    end
    pm_cur_drop = 1'b0;
    pm_mode = MODE_IDLE;
  endfunction

  function automatic void quoted_byte(logic [7:0] c);
    if (c == CH_QUOTE) begin
      close_token();
    end else if (c == CH_BSLASH) begin
      pm_mode = MODE_ESC;
    end else begin
      put_char_out(c);
    end
  endfunction

  function automatic void tokenize_byte(logic [7:0] c, logic eol);
    stp_n = 0;
    case (pm_mode)
      MODE_IDLE: begin
        if (!is_blank(c)) begin
          if (pm_kept >= pm_max) begin
            pm_cur_drop = 1'b1;
            pm_dropped = 1'b1;
          end else begin
            pm_cur_drop = 1'b0;
          end
          if (c == CH_QUOTE) begin
            pm_mode = MODE_STR;
          end else begin
            pm_mode = MODE_WORD;
            put_char_out(c);
          end
        end
      end
      MODE_WORD: begin
        if (is_blank(c)) begin
          close_token();
        end else begin
          put_char_out(c);
        end
      end
      MODE_STR: quoted_byte(c);
      default: begin
        pm_mode = MODE_STR;
        case (c)
          CH_LOW_R: put_char_out(CH_CR);
          CH_LOW_N: put_char_out(CH_LF);
          CH_LOW_T: put_char_out(CH_TAB);
          CH_QUOTE: put_char_out(CH_QUOTE);
          default: begin
            // Unknown escape: keep the backslash, then treat the byte as plain quoted text.
            put_char_out(CH_BSLASH);
            quoted_byte(c);
          end
        endcase
      end
    endcase
    if (eol) begin
      if (pm_mode != MODE_IDLE) begin
        if (pm_mode == MODE_ESC) begin
          put_char_out(CH_BSLASH);
        end
        close_token();
      end
      if (stp_n == 0) begin
        emit(8'h00, 1'b0);
      end
    end
    if (stp_n > 0) begin
      stp_ev[stp_n-1].last = 1'b1;
      stp_ev[stp_n-1].ldone = eol;
    end
    if (eol) begin
      pm_mode = MODE_IDLE;
      pm_kept = 8'd0;
      pm_dropped = 1'b0;
      pm_cur_drop = 1'b0;
    end
  endfunction

  task automatic log_mismatch(string why, tok_result_t ex, tok_result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("mismatch (%s) cycle %0d: expected ch=%h v=%b end=%b cnt=%0d ovf=%b ld=%b last=%b",
               why, cyc_count, ex.ch, ex.valid, ex.tend, ex.cnt, ex.ovf, ex.ldone, ex.last);
      $display("  got ch=%h v=%b end=%b cnt=%0d ovf=%b ld=%b last=%b",
               got.ch, got.valid, got.tend, got.cnt, got.ovf, got.ldone, got.last);
    end
  endtask

  // Accepted bytes feed the predictor first; results come from the registered queue.
  always @(posedge clk) begin
    tok_result_t got;
    tok_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        tokenize_byte(in_byte, in_end_of_line);
        if (row_typed) begin
          tok_out_q.push_back(row_expect);
        end else begin
          for (int k = 0; k < stp_n; k++) begin
            tok_out_q.push_back(stp_ev[k]);
          end
        end
      end
      if (out_valid && !out_stall) begin
        got = '{ch: out_char, valid: out_char_valid, tend: out_token_end,
                cnt: out_token_count, ovf: out_overflow, ldone: out_line_done,
                last: out_last_in_run};
        if (tok_out_q.size() == 0) begin
          log_mismatch("unexpected item", '0, got);
        end else begin
          want = tok_out_q.pop_front();
          if ((got.ch !== want.ch) || (got.valid !== want.valid) ||
              (got.tend !== want.tend) || (got.cnt !== want.cnt) ||
              (got.ovf !== want.ovf) || (got.ldone !== want.ldone) ||
              (got.last !== want.last)) begin
            log_mismatch("field", want, got);
          end
        end
      end
    end
  end

  // Result side: a random stall before each item, or one long hold when asked for.
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = quiet ? 0 : $urandom_range(0, 4);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_byte(logic [7:0] b, logic eol, bit typed, tok_result_t ex);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_end_of_line <= eol;
    row_typed <= typed;
    row_expect <= ex;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // The first edge lets the monitor record the results of the last accepted byte.
  task automatic wait_drained(int settle);
    @(posedge clk);
    while (tok_out_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_max_tokens(logic [7:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_MAX_TOKENS;
    pwdata <= {24'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pm_max = v;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] pick_escape();
    case ($urandom_range(0, 5))
      0: return CH_LOW_R;
      1: return CH_LOW_N;
      2: return CH_LOW_T;
      3: return CH_QUOTE;
      4: return CH_BSLASH;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed lines of words and quoted strings; one in ten is raw noise.
  task automatic make_line();
    int ntok;
    int len;
    logic [7:0] c;
    line_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 12);
      repeat (len) line_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      ntok = $urandom_range(0, 6);
      repeat (ntok) begin
        if ($urandom_range(0, 2) == 0) line_q.push_back(pick_blank());
        if ($urandom_range(0, 2) == 0) begin
          line_q.push_back(CH_QUOTE);
          len = $urandom_range(0, 5);
          repeat (len) begin
            if ($urandom_range(0, 4) == 0) begin
              line_q.push_back(CH_BSLASH);
              line_q.push_back(pick_escape());
            end else begin
              c = 8'($urandom_range(0, 255));
              line_q.push_back((c == CH_QUOTE || c == CH_BSLASH) ? CH_LOW_R : c);
            end
          end
          if ($urandom_range(0, 7) != 0) line_q.push_back(CH_QUOTE);
        end else begin
          len = $urandom_range(1, 5);
          for (int j = 0; j < len; j++) begin
            c = 8'($urandom_range(0, 255));
            if (is_blank(c) || (j == 0 && c == CH_QUOTE)) c = CH_LOW_N;
            line_q.push_back(c);
          end
        end
        if ($urandom_range(0, 3) != 0) line_q.push_back(pick_blank());
      end
    end
    if (line_q.size() == 0) line_q.push_back(pick_blank());
  endtask

  function automatic tok_result_t res1(logic [7:0] ch, logic v, logic e, logic [7:0] cnt,
                                       logic ovf, logic ld);
    return '{ch: ch, valid: v, tend: e, cnt: cnt, ovf: ovf, ldone: ld, last: 1'b1};
  endfunction

  function automatic dir_row_t d_byte(logic [7:0] b, logic eol);
    return '{is_cfg: 1'b0, b: b, eol: eol, typed: 1'b0, ex: '0};
  endfunction

  function automatic dir_row_t d_chk(logic [7:0] b, logic eol, tok_result_t ex);
    return '{is_cfg: 1'b0, b: b, eol: eol, typed: 1'b1, ex: ex};
  endfunction

  function automatic dir_row_t d_cfg(logic [7:0] v);
    return '{is_cfg: 1'b1, b: v, eol: 1'b0, typed: 1'b0, ex: '0};
  endfunction

  initial begin
    int items;
    logic [7:0] phase_max[8];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = 8'h00;
    in_end_of_line = 1'b0;
    row_typed = 1'b0;
    row_expect = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = 32'h0;
    pm_mode = MODE_IDLE;
    pm_kept = 8'd0;
    pm_max = MAX_TOKENS_RESET;
    pm_dropped = 1'b0;
    pm_cur_drop = 1'b0;

    // An empty line, a plain word with extreme bytes, an empty quoted pair,
    // every known escape, unknown escapes, an unterminated quote with a
    // pending backslash, then token dropping at the smallest limits.
    dir_tab.push_back(d_chk(CH_SPACE, 1'b1, res1(8'h00, 1'b0, 1'b0, 8'd0, 1'b0, 1'b1)));
    dir_tab.push_back(d_chk(8'h61, 1'b0, res1(8'h61, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0)));
    dir_tab.push_back(d_chk(8'h00, 1'b0, res1(8'h00, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0)));
    dir_tab.push_back(d_chk(8'hFF, 1'b0, res1(8'hFF, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0)));
    dir_tab.push_back(d_chk(CH_TAB, 1'b0, res1(8'h00, 1'b0, 1'b1, 8'd1, 1'b0, 1'b0)));
    dir_tab.push_back(d_byte(CH_QUOTE, 1'b0));
    dir_tab.push_back(d_chk(CH_QUOTE, 1'b0, res1(8'h00, 1'b0, 1'b1, 8'd2, 1'b0, 1'b0)));
    dir_tab.push_back(d_byte(CH_QUOTE, 1'b0));
    dir_tab.push_back(d_byte(CH_BSLASH, 1'b0));
    dir_tab.push_back(d_chk(CH_LOW_N, 1'b0, res1(CH_LF, 1'b1, 1'b0, 8'd2, 1'b0, 1'b0)));
    dir_tab.push_back(d_byte(CH_BSLASH, 1'b0));
    dir_tab.push_back(d_chk(CH_LOW_T, 1'b0, res1(CH_TAB, 1'b1, 1'b0, 8'd2, 1'b0, 1'b0)));
    dir_tab.push_back(d_byte(CH_BSLASH, 1'b0));
    dir_tab.push_back(d_chk(CH_LOW_R, 1'b0, res1(CH_CR, 1'b1, 1'b0, 8'd2, 1'b0, 1'b0)));
    dir_tab.push_back(d_byte(CH_BSLASH, 1'b0));
    dir_tab.push_back(d_chk(CH_QUOTE, 1'b0, res1(CH_QUOTE, 1'b1, 1'b0, 8'd2, 1'b0, 1'b0)));
    dir_tab.push_back(d_byte(CH_BSLASH, 1'b0));
    dir_tab.push_back(d_byte(8'h71, 1'b0));
    dir_tab.push_back(d_byte(CH_BSLASH, 1'b0));
    dir_tab.push_back(d_byte(CH_BSLASH, 1'b0));
    dir_tab.push_back(d_byte(CH_CR, 1'b1));
    dir_tab.push_back(d_byte(CH_QUOTE, 1'b0));
    dir_tab.push_back(d_byte(CH_BSLASH, 1'b1));
    dir_tab.push_back(d_cfg(8'd1));
    dir_tab.push_back(d_byte(8'h61, 1'b0));
    dir_tab.push_back(d_chk(CH_VT, 1'b0, res1(8'h00, 1'b0, 1'b1, 8'd1, 1'b0, 1'b0)));
    dir_tab.push_back(d_chk(8'h62, 1'b1, res1(8'h00, 1'b0, 1'b0, 8'd1, 1'b1, 1'b1)));
    dir_tab.push_back(d_cfg(8'd0));
    dir_tab.push_back(d_chk(8'h7A, 1'b1, res1(8'h00, 1'b0, 1'b0, 8'd0, 1'b1, 1'b1)));
    dir_tab.push_back(d_cfg(8'd255));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        in_valid <= 1'b0;
        wait_drained(4);
        write_max_tokens(dir_tab[i].b);
      end else begin
        send_byte(dir_tab[i].b, dir_tab[i].eol, dir_tab[i].typed, dir_tab[i].ex);
      end
    end

    phase_max = '{8'd1, 8'd0, 8'd255, 8'd3, 8'($urandom_range(1, 254)), 8'd2, 8'd64, 8'd255};
    foreach (phase_max[p]) begin
      in_valid <= 1'b0;
      wait_drained(4);
      write_max_tokens(phase_max[p]);
      quiet = (p == 4);
      // A long receiver hold lets the result queue fill so the input side stalls.
      if (p == 2 || p == 5) hold_cycles = HOLD_LONG;
      items = 0;
      while (items < PHASE_ITEMS) begin
        make_line();
        foreach (line_q[i]) begin
          send_byte(line_q[i], i == line_q.size() - 1, 1'b0, '0);
        end
        items += line_q.size();
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;
    wait_drained(10);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/qat_pkg.sv
rtl/qat_result_fifo.sv
rtl/quoted_argument_tokenizer_unit.sv
verif/tb_quoted_argument_tokenizer_unit.sv
